>>> sv/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// shared types, constants and helpers of the led fire effect generator
// ----------------------------------------------------------------------------
package lfe_pkg;

    localparam int LED_COUNT_DEF  = 32;
    localparam int SPARK_ZONE_DEF = 7;

    localparam logic [1:0] REG_COOLING = 2'd0;
    localparam logic [1:0] REG_SPARK   = 2'd1;
    localparam logic [1:0] REG_BURST   = 2'd2;
    localparam logic [1:0] REG_SEED    = 2'd3;

    localparam logic [7:0]  COOLING_RST = 8'd22;
    localparam logic [7:0]  SPARK_RST   = 8'd120;
    localparam logic [9:0]  BURST_RST   = 10'd150;
    localparam logic [31:0] SEED_RST    = 32'd1;

    localparam logic [12:0] TOTAL_MAX = 13'd8191;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COOL,
        ST_DIFF_RD,
        ST_DIFF_WR,
        ST_SPARK_TEST,
        ST_SPARK_CELL,
        ST_SPARK_RD,
        ST_SPARK_ADD,
        ST_END,
        ST_OUT_RD,
        ST_OUT
    } lfe_state_t;

    // xorshift32 step
    function automatic logic [31:0] xs32(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // heat to rgb palette
    // t = round(h*191/255) as (191h+127)/255 by reciprocal multiplication
    function automatic logic [23:0] heat_color(input logic [7:0] h);
        logic [31:0] prod;
        logic [7:0]  t;
        logic [7:0]  ramp;
        prod = 32'(h) * 32'd12566654 + 32'd8355838;
        t    = prod[31:24];
        ramp = {t[5:0], 2'b00};
        if (t > 8'h80)
            return {8'd255, 8'd255, ramp};
        else if (t > 8'h40)
            return {8'd255, ramp, 8'd0};
        else
            return {ramp, 16'd0};
    endfunction

endpackage

>>> sv/led_fire_effect_generator.sv
// ----------------------------------------------------------------------------
// led_fire_effect_generator
// fire animation on a strip of leds, one pixel stream per frame request
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// in       | in_valid/in_ready  | restart
// out      | out_valid/out_ready| pixel_index red green blue last phase
//          |                    | heat_total burned_out
// cfg      | cfg_we             | cfg_index cfg_data
//
// after the accepting cycle a frame runs a clear sweep (on a restart or the first frame),
// then cooling, on burning frames diffusion and a spark test (plus a spark when it fires),
// then end and output; one heat memory port pair and one prng stepper serve every phase.
// in_ready is high only in idle; the out register holds while out_ready is low.
// reset clears control, heat store cleared by a sweep on the first frame.
// ----------------------------------------------------------------------------
module led_fire_effect_generator
    import lfe_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int SPARK_ZONE = SPARK_ZONE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last,
    output logic        phase,
    output logic [12:0] heat_total,
    output logic        burned_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(LED_COUNT);
    localparam logic [AW-1:0] TOP = AW'(LED_COUNT - 1);
    localparam logic [15:0] ZONE16 = 16'(SPARK_ZONE);
    localparam logic [15:0] SPAN_RECIP = 16'(((2 ** 18) + LED_COUNT - 1) / LED_COUNT);

    lfe_state_t state_reg, state_next;

    logic [7:0]    cooling_reg;
    logic [7:0]    spark_reg;
    logic [9:0]    burst_reg;
    logic [31:0]   seed_reg;
    logic [31:0]   prng_reg, prng_next;
    logic [9:0]    frames_reg, frames_next;
    logic          phase_reg, phase_next;
    logic          fphase_reg, fphase_next;
    logic          burned_reg, burned_next;
    logic          dirty_reg, dirty_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [1:0]    sub_reg, sub_next;
    logic [12:0]   total_reg, total_next;
    logic [7:0]    hold_reg, hold_next;
    logic [8:0]    span_reg, span_next;
    logic [AW-1:0] cell_reg, cell_next;
    logic          ov_reg, ov_next;
    logic [4:0]    pidx_reg, pidx_next;
    logic [23:0]   rgb_reg, rgb_next;
    logic          olast_reg, olast_next;
    logic          ophase_reg, ophase_next;
    logic [12:0]   otot_reg, otot_next;
    logic          oburn_reg, oburn_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    logic [31:0]   draw;
    logic [15:0]   rnd;
    logic [24:0]   mul;
    logic [7:0]    cool_sel;
    logic [11:0]   cool_x10;
    logic [27:0]   span_prod;
    logic [8:0]    span_c;
    logic [8:0]    cool_amt;
    logic [7:0]    cooled;
    logic [9:0]    dsum;
    logic [19:0]   dprod;
    logic [8:0]    ssum;
    logic [AW-1:0] idx;
    logic [13:0]   tsum;

    lfe_heat_ram #(.DEPTH(LED_COUNT)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign draw = xs32(prng_reg);
    assign rnd  = draw[31:16];
    assign idx  = cnt_reg;
    assign mul  = 25'(rnd) * 25'(span_reg);
    assign cool_amt = mul[24:16];
    assign cooled   = (cool_amt > 9'(rdata)) ? 8'd0 : 8'(9'(rdata) - cool_amt);
    assign tsum     = 14'(total_reg) + 14'(cooled);
    // span = (c*10)/LED_COUNT + 2 by reciprocal multiplication
    assign cool_sel  = fphase_reg ? {1'b0, cooling_reg[7:1]} : cooling_reg;
    assign cool_x10  = 12'(cool_sel) * 12'd10;
    assign span_prod = 28'(cool_x10) * 28'(SPAN_RECIP);
    assign span_c    = 9'(span_prod[27:18]) + 9'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooling_reg <= COOLING_RST;
            spark_reg   <= SPARK_RST;
            burst_reg   <= BURST_RST;
            seed_reg    <= SEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COOLING: cooling_reg <= cfg_data[7:0];
                REG_SPARK:   spark_reg   <= cfg_data[7:0];
                REG_BURST:   burst_reg   <= cfg_data[9:0];
                REG_SEED:    seed_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            prng_reg   <= SEED_RST;
            frames_reg <= BURST_RST;
            fphase_reg <= 1'b0;
            dirty_reg  <= 1'b1;
            ov_reg     <= 1'b0;
            cnt_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            prng_reg   <= prng_next;
            frames_reg <= frames_next;
            fphase_reg <= fphase_next;
            dirty_reg  <= dirty_next;
            ov_reg     <= ov_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        burned_reg <= burned_next;
        total_reg <= total_next;
        hold_reg  <= hold_next;
        span_reg  <= span_next;
        cell_reg  <= cell_next;
        pidx_reg  <= pidx_next;
        rgb_reg   <= rgb_next;
        olast_reg <= olast_next;
        ophase_reg <= ophase_next;
        otot_reg  <= otot_next;
        oburn_reg <= oburn_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (restart || dirty_reg) ? ST_CLEAR : ST_COOL;
            ST_CLEAR:
                if (idx == TOP) state_next = ST_COOL;
            ST_COOL:
                if (sub_reg == 2'd2 && idx == TOP)
                    state_next = fphase_reg ? ST_END : ST_DIFF_RD;
            ST_DIFF_RD:
                if (sub_reg == 2'd2) state_next = ST_DIFF_WR;
            ST_DIFF_WR:
                state_next = (idx == AW'(2)) ? ST_SPARK_TEST : ST_DIFF_RD;
            ST_SPARK_TEST:
                state_next = (rnd[15:8] < spark_reg) ? ST_SPARK_CELL : ST_END;
            ST_SPARK_CELL:
                state_next = ST_SPARK_RD;
            ST_SPARK_RD:
                state_next = ST_SPARK_ADD;
            ST_SPARK_ADD:
                state_next = ST_END;
            ST_END:
                state_next = ST_OUT_RD;
            ST_OUT_RD:
                if (sub_reg == 2'd1 && (!ov_reg || out_ready)) state_next = ST_OUT;
            ST_OUT:
                if (!ov_reg || out_ready)
                    state_next = (idx == TOP) ? ST_IDLE : ST_OUT_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        prng_next   = prng_reg;
        frames_next = frames_reg;
        fphase_next = fphase_reg;
        phase_next  = phase_reg;
        burned_next = burned_reg;
        dirty_next  = dirty_reg;
        cnt_next    = cnt_reg;
        sub_next    = sub_reg;
        total_next  = total_reg;
        hold_next   = hold_reg;
        span_next   = span_reg;
        cell_next   = cell_reg;
        ov_next     = ov_reg;
        pidx_next   = pidx_reg;
        rgb_next    = rgb_reg;
        olast_next  = olast_reg;
        ophase_next = ophase_reg;
        otot_next   = otot_reg;
        oburn_next  = oburn_reg;
        we          = 1'b0;
        waddr       = idx;
        wdata       = 8'd0;
        raddr       = idx;
        dsum        = '0;
        dprod       = '0;
        ssum        = '0;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cnt_next    = '0;
                    sub_next    = '0;
                    total_next  = '0;
                    burned_next = 1'b0;
                    if (restart)
                    begin
                        prng_next   = (seed_reg == 32'd0) ? 32'd1 : seed_reg;
                        frames_next = burst_reg;
                        fphase_next = 1'b0;
                    end
                end
            ST_CLEAR:
            begin
                we = 1'b1;
                dirty_next = 1'b0;
                cnt_next = (idx == TOP) ? '0 : cnt_reg + 1'b1;
            end
            ST_COOL:
            begin
                phase_next = fphase_reg;
                case (sub_reg)
                    2'd0:
                    begin
                        span_next = span_c;
                        sub_next  = 2'd1;
                    end
                    2'd1:
                        sub_next = 2'd2;
                    default:
                    begin
                        prng_next  = draw;
                        we         = 1'b1;
                        wdata      = cooled;
                        total_next = (tsum > 14'(TOTAL_MAX)) ? TOTAL_MAX : tsum[12:0];
                        sub_next   = 2'd0;
                        cnt_next   = (idx == TOP) ? TOP : cnt_reg + 1'b1;
                    end
                endcase
            end
            ST_DIFF_RD:
                case (sub_reg)
                    2'd0:
                    begin
                        raddr    = idx - AW'(1);
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        raddr     = idx - AW'(2);
                        hold_next = rdata;
                        sub_next  = 2'd2;
                    end
                    default:
                    begin
                        raddr    = idx - AW'(2);
                        sub_next = 2'd2;
                    end
                endcase
            ST_DIFF_WR:
            begin
                // divide by 3 as multiply by 683 and shift by 11
                dsum     = 10'(hold_reg) + {1'b0, rdata, 1'b0};
                dprod    = 20'(dsum) * 20'd683;
                we       = 1'b1;
                wdata    = 8'(dprod >> 11);
                sub_next = 2'd0;
                cnt_next = cnt_reg - 1'b1;
            end
            ST_SPARK_TEST:
                prng_next = draw;
            ST_SPARK_CELL:
            begin
                prng_next = draw;
                cell_next = ((32'(rnd) * 32'(ZONE16)) >> 16) >= 32'(LED_COUNT) ? TOP
                          : AW'((32'(rnd) * 32'(ZONE16)) >> 16);
            end
            ST_SPARK_RD:
                raddr = cell_reg;
            ST_SPARK_ADD:
            begin
                prng_next = draw;
                ssum  = 9'(rdata) + 9'd160 + 9'((24'(rnd) * 24'd95) >> 16);
                we    = 1'b1;
                waddr = cell_reg;
                wdata = ssum[8] ? 8'd255 : ssum[7:0];
            end
            ST_END:
            begin
                cnt_next = '0;
                sub_next = '0;
                if (!fphase_reg)
                begin
                    if (frames_reg <= 10'd1)
                    begin
                        frames_next = '0;
                        fphase_next = 1'b1;
                    end
                    else
                        frames_next = frames_reg - 1'b1;
                end
                else if (total_reg == 13'd0)
                begin
                    burned_next = 1'b1;
                    fphase_next = 1'b0;
                    frames_next = burst_reg;
                end
            end
            ST_OUT_RD:
            begin
                raddr = TOP - idx;
                if (sub_reg == 2'd0)
                    sub_next = 2'd1;
            end
            ST_OUT:
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    pidx_next   = 5'(idx);
                    rgb_next    = heat_color(rdata);
                    olast_next  = (idx == TOP);
                    ophase_next = phase_reg;
                    otot_next   = (idx == TOP) ? total_reg : 13'd0;
                    oburn_next  = (idx == TOP) ? burned_reg : 1'b0;
                    cnt_next    = cnt_reg + 1'b1;
                    sub_next    = 2'd0;
                end
            default: ;
        endcase
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ov_reg;
    assign pixel_index = pidx_reg;
    assign red         = rgb_reg[23:16];
    assign green       = rgb_reg[15:8];
    assign blue        = rgb_reg[7:0];
    assign last        = olast_reg;
    assign phase       = ophase_reg;
    assign heat_total  = otot_reg;
    assign burned_out  = oburn_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second frame while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_index)))
        else $error("pixel dropped under stall");
    a_burn_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && burned_out) |-> (last && phase))
        else $error("burned_out off the last cooldown pixel");
    a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (heat_total == 13'd0))
        else $error("heat total outside last pixel");

endmodule

>>> sv/lfe_heat_ram.sv
// ----------------------------------------------------------------------------
// lfe_heat_ram
// heat store, one write port and one registered read port
// ----------------------------------------------------------------------------
module lfe_heat_ram
    import lfe_pkg::*;
#(
    parameter int DEPTH = LED_COUNT_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
